@@ rtl/ddw_pkg.sv @@
// ----------------------------------------------------------------------------
// ddw_pkg
// Shared types and constants of the decimal digit display writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddw_pkg;

   // Action codes on the request word.
   localparam logic [1:0] ACTION_FULL  = 2'd0;
   localparam logic [1:0] ACTION_UPPER = 2'd1;
   localparam logic [1:0] ACTION_LOWER = 2'd2;

   // Digits in each display area.
   localparam logic [3:0] FULL_DIGITS = 4'd8;
   localparam logic [3:0] HALF_DIGITS = 4'd4;

   // Weight of the top digit of each area.
   localparam logic [23:0] FULL_WEIGHT = 24'd10000000;
   localparam logic [23:0] HALF_WEIGHT = 24'd1000;

   // Reciprocals for the top quotient: q = (value * RECIP) >> SHIFT, exact
   // for every 32-bit value.
   localparam logic [31:0] FULL_RECIP = 32'd3602879702;
   localparam logic [31:0] HALF_RECIP = 32'd274877907;
   localparam int          FULL_SHIFT = 55;
   localparam int          HALF_SHIFT = 38;

   typedef enum logic [1:0] {
      AREA_FULL,
      AREA_UPPER,
      AREA_LOWER
   } area_type;

   // One classified word passed from the front to the digit unit.
   typedef struct packed {
      logic [3:0]  top;    // top digit, quotient modulo 16
      logic [23:0] rest;   // remainder below the top weight
      area_type    area;
      logic [3:0]  count;  // clamped to the area width, never zero
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   // Power of ten for a digit exponent of zero to six.
   function automatic logic [23:0] pow10(input logic [2:0] e);
      logic [23:0] p;
      case (e)
         3'd0: p = 24'd1;
         3'd1: p = 24'd10;
         3'd2: p = 24'd100;
         3'd3: p = 24'd1000;
         3'd4: p = 24'd10000;
         3'd5: p = 24'd100000;
         3'd6: p = 24'd1000000;
         default: p = 24'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ddw_front.sv @@
// ----------------------------------------------------------------------------
// ddw_front
// Accepts request words, drops those that write nothing, and splits off the
// top digit of the area in a two-stage multiply pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_front
   import ddw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [31:0] req_value,
   input  wire logic [3:0]  req_digit_count,
   input  wire logic [1:0]  req_action,
   output logic             cmd_push,
   output cmd_type          cmd_data,
   input  wire logic        cmd_full
);

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_value_ff;
   logic [3:0]  s1_count_ff;
   area_type    s1_area_ff;
   logic [63:0] s1_prod_ff;

   logic        s2_valid_ff, s2_valid_in;
   logic [31:0] s2_value_ff;
   logic [3:0]  s2_count_ff;
   area_type    s2_area_ff;
   logic [3:0]  s2_top_ff;
   logic [31:0] s2_qw_ff;

   logic        accept, useful;
   logic        s1_free, s2_free;
   area_type    area_in;
   logic [3:0]  width_in, count_in;
   logic [31:0] recip_in;
   logic [22:0] quot;
   logic [23:0] weight;
   logic [46:0] qw_full;
   logic [31:0] rest_wide;

   // Classification of the incoming word.
   always_comb begin
      useful   = 1'b1;
      area_in  = AREA_FULL;
      width_in = FULL_DIGITS;
      recip_in = FULL_RECIP;
      case (req_action)
         ACTION_FULL: begin
            area_in  = AREA_FULL;
            width_in = FULL_DIGITS;
            recip_in = FULL_RECIP;
         end
         ACTION_UPPER: begin
            area_in  = AREA_UPPER;
            width_in = HALF_DIGITS;
            recip_in = HALF_RECIP;
         end
         ACTION_LOWER: begin
            area_in  = AREA_LOWER;
            width_in = HALF_DIGITS;
            recip_in = HALF_RECIP;
         end
         default: begin
            useful = 1'b0;
         end
      endcase
      count_in = (req_digit_count > width_in) ? width_in : req_digit_count;
      if (count_in == 4'd0) begin
         useful = 1'b0;
      end
   end

   assign s2_free  = !s2_valid_ff || !cmd_full;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_full = !s1_free;
   assign accept   = req_push && s1_free;

   assign s1_valid_in = s1_free ? (accept && useful) : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   // Top quotient from the registered reciprocal product.
   always_comb begin
      case (s1_area_ff)
         AREA_FULL: begin
            quot   = {14'd0, s1_prod_ff[63:FULL_SHIFT]};
            weight = FULL_WEIGHT;
         end
         AREA_UPPER, AREA_LOWER: begin
            quot   = s1_prod_ff[HALF_SHIFT+22:HALF_SHIFT];
            weight = HALF_WEIGHT;
         end
         default: begin
            quot   = 23'd0;
            weight = FULL_WEIGHT;
         end
      endcase
      qw_full = quot * weight;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_value_ff <= req_value;
         s1_count_ff <= count_in;
         s1_area_ff  <= area_in;
         s1_prod_ff  <= req_value * recip_in;
      end
      if (s2_free) begin
         s2_value_ff <= s1_value_ff;
         s2_count_ff <= s1_count_ff;
         s2_area_ff  <= s1_area_ff;
         s2_top_ff   <= quot[3:0];
         s2_qw_ff    <= qw_full[31:0];
      end
   end

   // The remainder is below the top weight, so it fits in 24 bits.
   assign rest_wide      = s2_value_ff - s2_qw_ff;
   assign cmd_push       = s2_valid_ff && !cmd_full;
   assign cmd_data.top   = s2_top_ff;
   assign cmd_data.rest  = rest_wide[23:0];
   assign cmd_data.area  = s2_area_ff;
   assign cmd_data.count = s2_count_ff;

endmodule

`default_nettype wire

@@ rtl/ddw_queue.sv @@
// ----------------------------------------------------------------------------
// ddw_queue
// Small first-in first-out queue of classified words between the front and
// the digit unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_queue
   import ddw_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   cmd_type          store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == DEPTH_CNT);
   assign not_empty = (fill_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ddw_back.sv @@
// ----------------------------------------------------------------------------
// ddw_back
// Digit unit: walks the area's digits from the top, one a cycle unless a
// result waits; the requested low-order digits go to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_back
   import ddw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd_data,
   input  wire logic       cmd_ready,
   output logic            cmd_pop,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [2:0]      rsp_position,
   output logic [3:0]      rsp_digit,
   output logic            rsp_last
);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [2:0]     step_ff, step_in;
   logic [23:0]    rest_ff, rest_in;
   logic           out_valid_ff, out_valid_in;
   logic [2:0]     out_position_ff;
   logic [3:0]     out_digit_ff;
   logic           out_last_ff;

   logic           adv, step, load, at_last, emit;
   logic [2:0]     last_step, first_step, base, expo;
   logic [3:0]     width;
   logic [23:0]    pow;
   logic [23:0]    cand [10];
   logic [3:0]     dsel;
   logic [3:0]     digit_now;
   logic [23:0]    rest_next;

   assign adv = !out_valid_ff || rsp_pop;

   always_comb begin
      width     = (cmd_ff.area == AREA_FULL) ? FULL_DIGITS : HALF_DIGITS;
      last_step = 3'(width - 4'd1);
      first_step = 3'(width - cmd_ff.count);
      base      = (cmd_ff.area == AREA_UPPER) ? 3'd4 : 3'd0;
      at_last   = (step_ff == last_step);
      emit      = (step_ff >= first_step);
      expo      = last_step - step_ff;
      pow       = pow10(expo);
   end

   // Below the top digit every digit is under ten: pick the largest
   // multiple of the current weight that fits in the remainder.
   always_comb begin
      cand[0] = 24'd0;
      for (int i = 1; i < 10; i++) begin
         cand[i] = 24'(pow * 24'(i));
      end
      dsel = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (rest_ff >= cand[i]) begin
            dsel = 4'(i);
         end
      end
      if (step_ff == 3'd0) begin
         digit_now = cmd_ff.top;
         rest_next = rest_ff;
      end else begin
         digit_now = dsel;
         rest_next = rest_ff - cand[dsel];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_ready) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (adv && at_last && !cmd_ready) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      step    = 1'b0;
      load    = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            load = cmd_ready;
         end
         BACK_RUN: begin
            step = adv;
            load = adv && at_last && cmd_ready;
         end
         default: begin
            step = 1'b0;
            load = 1'b0;
         end
      endcase
      cmd_pop = load;
   end

   always_comb begin
      step_in      = step_ff;
      rest_in      = rest_ff;
      out_valid_in = out_valid_ff;
      if (step) begin
         step_in = step_ff + 3'd1;
         rest_in = rest_next;
      end
      if (load) begin
         step_in = 3'd0;
         rest_in = cmd_data.rest;
      end
      if (adv) begin
         out_valid_in = step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      if (load) begin
         cmd_ff <= cmd_data;
      end
      if (adv) begin
         out_position_ff <= base + step_ff;
         out_digit_ff    <= digit_now;
         out_last_ff     <= at_last;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_position = out_position_ff;
   assign rsp_digit    = out_digit_ff;
   assign rsp_last     = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/decimal_digit_display_writer.sv @@
// ----------------------------------------------------------------------------
// decimal_digit_display_writer
// Turns a 32-bit binary value into decimal digit writes for an eight-digit
// display, for the whole display or for either half of it.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Word
//   req_      in         push / full      value, digit_count, action
//   rsp_      out        pop / empty      position, digit, last
//
// A word with action 0 covers display positions 0 to 7, action 1 positions
// 4 to 7 and action 2 positions 0 to 3. Each accepted word gives one result
// per written position, in ascending position order, with last set on the
// final one. Words with a digit count of zero or an unused action give none.
//
// The front accepts one word a cycle while req_full is low. The digit unit
// steps through every digit of the area, one a cycle unless a result waits
// unpopped, eight for the full display and four for a half, also through
// digits that are not written. A word passes the two front stages, the
// queue and the digit unit's command register before its first result
// reaches the result register. Reset clears the pipeline valid bits, the
// queue and the result register; no clearing pass is needed. Pop held low
// while a result waits stalls the digit unit, and the front keeps taking
// words until the queue and both front stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_digit_display_writer
   import ddw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [31:0] req_value,
   input  wire logic [3:0]  req_digit_count,
   input  wire logic [1:0]  req_action,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_position,
   output logic [3:0]       rsp_digit,
   output logic             rsp_last
);

   // Classified words travel from the front to the digit unit through the
   // queue, so a stalled result side does not stop the front at once.
   logic    front_push;
   cmd_type front_data;
   logic    queue_full;
   logic    queue_ready;
   logic    back_pop;
   cmd_type queue_data;

   // The front works out the top digit and the remainder beneath it.
   ddw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .req_digit_count (req_digit_count),
      .req_action      (req_action),
      .cmd_push        (front_push),
      .cmd_data        (front_data),
      .cmd_full        (queue_full)
   );

   ddw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_data  (queue_data),
      .not_empty (queue_ready)
   );

   // The digit unit takes the next word on the same edge as it finishes
   // the current one, so back-to-back words leave the digit unit no idle step.
   ddw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_data     (queue_data),
      .cmd_ready    (queue_ready),
      .cmd_pop      (back_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_position (rsp_position),
      .rsp_digit    (rsp_digit),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire
